[rtl/wbs4_pkg.sv]
// shared types, constants and the s-box for the white-box sm4 engine
`default_nettype none

package wbs4_pkg;

  localparam int ROUND_COUNT_DEF = 32;
  localparam int ADDR_W          = 18;
  localparam int TBL_BLOCKS      = 168;
  localparam int BANK_DEPTH      = TBL_BLOCKS * 256;
  localparam int BANK_AW         = $clog2(BANK_DEPTH);

  localparam logic [7:0] BLK_CC  = 8'd96;
  localparam logic [7:0] BLK_DD  = 8'd128;
  localparam logic [7:0] BLK_SEE = 8'd160;
  localparam logic [7:0] BLK_FEE = 8'd164;
  localparam logic [7:0] BLK_END = 8'(TBL_BLOCKS);

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_ENCRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEE,
    ST_RND,
    ST_FEE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEE,
    OP_MM0,
    OP_MM1,
    OP_MM2,
    OP_CC,
    OP_DD,
    OP_FEE
  } op_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] idx;
    logic [31:0]        data;
  } bank_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

`default_nettype wire

[rtl/wbs4_bank.sv]
// one byte-position bank of the lookup table memory, registered read
`default_nettype none

module wbs4_bank (
  input  logic                         clk,
  input  wbs4_pkg::bank_wr_t           wr,
  input  logic                         rd_en,
  input  logic [wbs4_pkg::BANK_AW-1:0] rd_idx,
  output logic [31:0]                  rd_data
);
  import wbs4_pkg::*;

  logic [31:0] mem [0:BANK_DEPTH-1];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/white_box_sm4_table_encrypt.sv]
// top level: table-driven white-box sm4 encryption with table load port
//
//  channel | dir | tdata                                      | tuser
//  --------+-----+--------------------------------------------+---------------
//  in_     | in  | address, table word, block high, block low | command
//  out_    | out | ciphertext high, ciphertext low            | -
//
//  an encrypt steps through the see lookups, the rounds and the fee lookups from transfer
//  to result: one four-bank table read per cycle, five lookups per round
//  input is taken again as soon as the engine is idle
//  a result waiting on out_tready stalls the final load, and with it the next transfer
//  reset clears control only; table contents are undefined until written
`default_nettype none

module white_box_sm4_table_encrypt #(
  parameter int ROUND_COUNT = wbs4_pkg::ROUND_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [17:0] table_address, [49:18] table_word, [113:50] block_high,
  // [177:114] block_low, [183:178] zero
  input  logic [183:0] in_tdata,
  // [0] command
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] ciphertext_high, [127:64] ciphertext_low
  output logic [127:0] out_tdata
);
  import wbs4_pkg::*;

  localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  state_t          state_r, state_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [2:0]      lane_r, lane_nxt;
  logic [RW-1:0]   rnd_r, rnd_nxt;
  op_t             rd_op_r, op_iss;
  logic [1:0]      rd_idx_r;
  logic [7:0]      iss_blk;
  logic [31:0]     iss_word;
  logic            shift_en;
  logic            load_out;

  logic [31:0]     w_r [4];
  logic [31:0]     acc_r, sb_r, cc_r;
  logic            out_valid_r;
  logic [127:0]    out_data_r;

  logic [31:0]     rd_q [4];
  logic [31:0]     q4;
  logic [7:0]      rnd_blk;
  logic            in_xfer, enc_go, write_go;
  logic [ADDR_W-1:0] wr_addr;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign enc_go    = in_xfer && (in_tuser == CMD_ENCRYPT);
  assign wr_addr   = in_tdata[17:0];
  assign write_go  = in_xfer && (in_tuser == CMD_WRITE) && (wr_addr[17:10] < BLK_END);
  assign rnd_blk   = 8'(rnd_r);
  assign q4        = rd_q[0] ^ rd_q[1] ^ rd_q[2] ^ rd_q[3];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bank_wr_t wr;
    assign wr.en   = write_go && (wr_addr[9:8] == 2'(b));
    assign wr.idx  = {wr_addr[17:10], wr_addr[7:0]};
    assign wr.data = in_tdata[49:18];
    wbs4_bank u_bank (
      .clk     (clk),
      .wr      (wr),
      .rd_en   (op_iss != OP_NONE),
      .rd_idx  ({iss_blk, iss_word[31-8*b -: 8]}),
      .rd_data (rd_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      lane_r      <= '0;
      rnd_r       <= '0;
      rd_op_r     <= OP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      lane_r  <= lane_nxt;
      rnd_r   <= rnd_nxt;
      rd_op_r <= op_iss;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    lane_nxt  = lane_r;
    rnd_nxt   = rnd_r;
    op_iss    = OP_NONE;
    iss_blk   = '0;
    iss_word  = '0;
    shift_en  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (enc_go) begin
          state_nxt = ST_SEE;
          idx_nxt   = '0;
        end
      end
      ST_SEE: begin
        op_iss   = OP_SEE;
        iss_blk  = BLK_SEE + 8'(idx_r);
        iss_word = w_r[idx_r];
        idx_nxt  = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          state_nxt = ST_RND;
          lane_nxt  = '0;
          rnd_nxt   = '0;
        end
      end
      ST_RND: begin
        lane_nxt = lane_r + 3'd1;
        unique case (lane_r)
          3'd0: begin
            op_iss   = OP_MM0;
            iss_blk  = (rnd_blk << 1) + rnd_blk;
            iss_word = w_r[1];
          end
          3'd1: begin
            op_iss   = OP_MM1;
            iss_blk  = (rnd_blk << 1) + rnd_blk + 8'd1;
            iss_word = w_r[2];
          end
          3'd2: begin
            op_iss   = OP_MM2;
            iss_blk  = (rnd_blk << 1) + rnd_blk + 8'd2;
            iss_word = w_r[3];
          end
          3'd3: begin
            op_iss   = OP_CC;
            iss_blk  = BLK_CC + rnd_blk;
            iss_word = w_r[0];
            shift_en = 1'b1;
          end
          default: begin
            op_iss   = OP_DD;
            iss_blk  = BLK_DD + rnd_blk;
            iss_word = sb_r;
            lane_nxt = '0;
            rnd_nxt  = rnd_r + RW'(1);
            if (rnd_r == RW'(ROUND_COUNT - 1)) begin
              state_nxt = ST_FEE;
              idx_nxt   = '0;
            end
          end
        endcase
      end
      ST_FEE: begin
        op_iss   = OP_FEE;
        iss_blk  = BLK_FEE + 8'(2'd3 - idx_r);
        iss_word = w_r[idx_r];
        idx_nxt  = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if ((rd_op_r == OP_NONE) && (!out_valid_r || out_tready)) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    if (enc_go) begin
      w_r[0] <= in_tdata[113:82];
      w_r[1] <= in_tdata[81:50];
      w_r[2] <= in_tdata[177:146];
      w_r[3] <= in_tdata[145:114];
    end else begin
      case (rd_op_r) inside
        OP_SEE, OP_FEE: w_r[rd_idx_r] <= q4;
        OP_DD:          w_r[3] <= cc_r ^ q4;
        default: ;
      endcase
      if (shift_en) begin
        w_r[0] <= w_r[1];
        w_r[1] <= w_r[2];
        w_r[2] <= w_r[3];
      end
    end
    case (rd_op_r)
      OP_MM0:  acc_r <= q4;
      OP_MM1:  acc_r <= acc_r ^ q4;
      OP_MM2:  sb_r  <= sbox_word(acc_r ^ q4);
      OP_CC:   cc_r  <= q4;
      default: ;
    endcase
    if (load_out) begin
      out_data_r <= {w_r[1], w_r[0], w_r[3], w_r[2]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    write_go |-> (state_r == ST_IDLE))
    else $error("table write outside idle");

  a_dd_after_cc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RND && lane_r == 3'd4) |-> (rd_op_r == OP_CC))
    else $error("dd lookup not preceded by cc lookup");

  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (rd_op_r == OP_NONE))
    else $error("table read in flight while idle");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE ##1 state_r == ST_IDLE) |-> out_valid_r)
    else $error("encrypt finished without a result");

endmodule

`default_nettype wire

[bench/white_box_sm4_table_encrypt_test.sv]
// self-checking bench for the table-driven white-box sm4 engine
module white_box_sm4_table_encrypt_test;
  import wbs4_pkg::*;

  localparam int ROUNDS       = 32;
  localparam int TABLE_WORDS  = 172032;
  localparam int MM_AT        = 0;
  localparam int CC_AT        = int'(BLK_CC) * 1024;
  localparam int DD_AT        = int'(BLK_DD) * 1024;
  localparam int SEE_AT       = int'(BLK_SEE) * 1024;
  localparam int FEE_AT       = int'(BLK_FEE) * 1024;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_AFTER   = 30;
  localparam int HOLD_CYCLES  = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 20000;
  localparam int REPORT_MAX   = 10;

  class cipher_scoreboard;
    bit [31:0]  lut [TABLE_WORDS];
    bit [127:0] ciphertext_due [$];
    int         faults;
    int         writes;
    int         dropped_writes;
    int         encrypts;
    int         results;

    function bit [31:0] gather4(int base, bit [31:0] w);
      return lut[base + w[31:24]] ^ lut[base + 256 + w[23:16]]
           ^ lut[base + 512 + w[15:8]] ^ lut[base + 768 + w[7:0]];
    endfunction

    function bit [127:0] encipher(bit [63:0] hi, bit [63:0] lo);
      bit [31:0] w [4];
      bit [31:0] mix;
      bit [31:0] fresh;
      w[0] = hi[63:32];
      w[1] = hi[31:0];
      w[2] = lo[63:32];
      w[3] = lo[31:0];
      for (int t = 0; t < 4; t++) w[t] = gather4(SEE_AT + t * 1024, w[t]);
      for (int r = 0; r < ROUNDS; r++) begin
        mix = gather4(MM_AT + (r * 3) * 1024, w[1])
            ^ gather4(MM_AT + (r * 3 + 1) * 1024, w[2])
            ^ gather4(MM_AT + (r * 3 + 2) * 1024, w[3]);
        mix = {SBOX[mix[31:24]], SBOX[mix[23:16]], SBOX[mix[15:8]], SBOX[mix[7:0]]};
        fresh = gather4(CC_AT + r * 1024, w[0]) ^ gather4(DD_AT + r * 1024, mix);
        w[0] = w[1];
        w[1] = w[2];
        w[2] = w[3];
        w[3] = fresh;
      end
      for (int t = 0; t < 4; t++) w[t] = gather4(FEE_AT + (3 - t) * 1024, w[t]);
      return {w[1], w[0], w[3], w[2]};
    endfunction

    function void note_transfer(logic cmd, bit [17:0] addr, bit [31:0] word,
                                bit [63:0] hi, bit [63:0] lo);
      if (cmd == CMD_WRITE) begin
        if (addr < TABLE_WORDS) begin
          lut[addr] = word;
          writes++;
        end else begin
          dropped_writes++;
        end
      end else begin
        ciphertext_due.push_back(encipher(hi, lo));
        encrypts++;
      end
    endfunction

    function void check_result(logic [127:0] got);
      bit [127:0] want;
      results++;
      if (ciphertext_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX) $display("unexpected result %h", got);
        return;
      end
      want = ciphertext_due.pop_front();
      if (got[63:0] !== want[63:0] || got[127:64] !== want[127:64]) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("result %0d mismatch: high exp %h got %h, low exp %h got %h",
                   results, want[63:0], got[63:0], want[127:64], got[127:64]);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [183:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;

  cipher_scoreboard sb = new();
  int stall_cycles = 0;

  white_box_sm4_table_encrypt #(.ROUND_COUNT(ROUNDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // called just after a falling edge, returns just after a falling edge
  task automatic offer(logic cmd, bit [17:0] addr, bit [31:0] word,
                       bit [63:0] hi, bit [63:0] lo, bit calm);
    while (!calm && $urandom_range(99) < 15) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {6'b0, lo, hi, word, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_transfer(cmd, addr, word, hi, lo);
    @(negedge clk);
  endtask

  task automatic put_word(bit [17:0] addr, bit [31:0] word, bit calm = 1'b0);
    offer(CMD_WRITE, addr, word, {$urandom, $urandom}, {$urandom, $urandom}, calm);
  endtask

  task automatic put_block(bit [63:0] hi, bit [63:0] lo, bit calm);
    offer(CMD_ENCRYPT, 18'($urandom), $urandom, hi, lo, calm);
  endtask

  // receiver: random stalls, one long hold-off, and a stretch with none
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    while (sb.encrypts < HOLD_AFTER) begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= 15);
    end
    @(negedge clk);
    out_tready = 1'b0;
    repeat (HOLD_CYCLES) @(negedge clk);
    forever begin
      out_tready = (sb.results >= 100 && sb.results < 160) || ($urandom_range(99) >= 15);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("no transfer for %0d cycles, %0d results outstanding",
                   stall_cycles, sb.ciphertext_due.size());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int pick;
    bit calm;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = CMD_WRITE;
    in_tdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every table entry gets written before any encrypt can read it
    for (int a = 0; a < TABLE_WORDS; a++) put_word(18'(a), $urandom);

    put_word(18'd0, 32'h0);
    put_word(18'(TABLE_WORDS - 1), 32'hffff_ffff);
    put_word(18'(TABLE_WORDS), 32'hffff_ffff);
    put_word(18'h3ffff, 32'h0);
    put_block(64'h0, 64'h0, 1'b0);
    put_block('1, '1, 1'b0);
    put_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
    put_word(18'(SEE_AT), $urandom);
    put_word(18'(FEE_AT), $urandom);
    put_word(18'(FEE_AT + 4095), $urandom);
    put_block(64'h0, 64'h0, 1'b0);
    put_word(18'(CC_AT), $urandom);
    put_word(18'(DD_AT), $urandom);
    put_word(18'(CC_AT - 1), $urandom);
    put_word(18'(DD_AT - 1), $urandom);
    put_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    offer(CMD_ENCRYPT, 18'h3ffff, 32'hffff_ffff, 64'h5555_5555_5555_5555,
          64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    put_block(64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      calm = (i >= 150 && i < 260);
      if (pick < 55)
        put_block({$urandom, $urandom}, {$urandom, $urandom}, calm);
      else if (pick < 88)
        put_word(18'($urandom_range(TABLE_WORDS - 1)), $urandom, calm);
      else
        put_word(18'($urandom_range(18'h3ffff, TABLE_WORDS)), $urandom, calm);
    end
    in_tvalid = 1'b0;

    while (sb.ciphertext_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: %0d table writes (full fill included), %0d dropped out-of-range writes",
             sb.writes, sb.dropped_writes);
    $display("covered: %0d encrypt transfers, %0d results checked, %0d faults",
             sb.encrypts, sb.results, sb.faults);
    if (sb.faults == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
